// ===== src/rwa_pkg.sv =====
package rwa_pkg;

    localparam int WINDOW_DEPTH_DEF = 32;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int CFG_W            = 6;
    localparam logic [CFG_W-1:0] WIN_RESET = 6'd30;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_START,
        S_DIV,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_store_ctl;

endpackage

// ===== src/rwa_store.sv =====
module rwa_store #(
    parameter int DEPTH = rwa_pkg::WINDOW_DEPTH_DEF,
    parameter int DW    = rwa_pkg::SAMPLE_WIDTH_DEF,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rwa_pkg::t_store_ctl  i_ctl,
    input  logic [AW-1:0]        i_addr,
    input  logic [DW-1:0]        i_wr_data,
    output logic [DW-1:0]        o_rd_data
);
    import rwa_pkg::*;

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    // slot valid bits; an empty slot reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_hit <= r_vld[i_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

// ===== src/rwa_div.sv =====
module rwa_div #(
    parameter int TOT_W = 29,
    parameter int NW    = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [TOT_W-1:0] i_total,
    input  logic [NW-1:0]           i_divisor,
    output logic                    o_done,
    output logic                    o_neg,
    output logic [TOT_W-1:0]        o_quot
);
    import rwa_pkg::*;

    localparam int CW = $clog2(TOT_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic             r_neg;
    logic [TOT_W-1:0] r_shr;
    logic [NW-1:0]    r_rem;
    logic [NW-1:0]    r_div;
    logic [NW:0]      trial;
    logic             q_bit;

    // one quotient bit per cycle, dividend shifts out as quotient shifts in
    assign trial = {r_rem, r_shr[TOT_W-1]};
    assign q_bit = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(TOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_total[TOT_W-1];
            r_shr <= i_total[TOT_W-1] ? (-i_total) : i_total;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_shr <= {r_shr[TOT_W-2:0], q_bit};
            r_rem <= q_bit ? NW'(trial - {1'b0, r_div}) : trial[NW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_neg  = r_neg;
    assign o_quot = r_shr;

endmodule

// ===== src/rolling_window_average_core.sv =====
// Boxcar moving average. Each accepted sample replaces the oldest slot of a
// circular window of window_size slots (0 acts as 1, values above
// WINDOW_DEPTH act as WINDOW_DEPTH); the running total is updated and then
// divided by the window size with truncation toward zero. One result per
// sample. The division is done by a bit-serial divider that produces one
// quotient bit per cycle; the next sample is taken once the result is in
// the output register. Slots are empty after reset and after a
// window_size write, and empty slots count as zero.
module rolling_window_average_core #(
    parameter int WINDOW_DEPTH = rwa_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = rwa_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_sample,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]  o_average,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rwa_pkg::CFG_W-1:0]       i_cfg_window_size
);
    import rwa_pkg::*;

    localparam int PW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int NW    = $clog2(WINDOW_DEPTH + 1);
    localparam int TOT_W = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH);

    t_state                    r_state, n_state;
    logic [CFG_W-1:0]          r_win;
    logic [PW-1:0]             r_pos;
    logic [PW-1:0]             r_slot;
    logic signed [TOT_W-1:0]   r_total;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                      r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_average;

    logic [NW-1:0]             n_eff;
    logic [PW-1:0]             pos_eff;
    logic [NW-1:0]             pos_inc;
    logic                      in_xfer;
    logic                      cfg_xfer;
    logic                      out_free;
    logic                      out_load;
    logic                      div_start;
    logic                      div_done;
    logic                      div_neg;
    logic [TOT_W-1:0]          div_quot;
    logic [TOT_W-1:0]          avg_full;
    logic [SAMPLE_WIDTH-1:0]   old_slot;
    t_store_ctl                store_ctl;

    always_comb begin
        if (r_win == '0) begin
            n_eff = NW'(1);
        end else if (int'(r_win) > WINDOW_DEPTH) begin
            n_eff = NW'(WINDOW_DEPTH);
        end else begin
            n_eff = NW'(r_win);
        end
    end

    assign pos_eff  = (NW'(r_pos) >= n_eff) ? '0 : r_pos;
    assign pos_inc  = NW'(r_slot) + NW'(1);

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_xfer     = i_valid && (r_state == S_IDLE);
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_START;
            S_START:  n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        store_ctl.rd_en = 1'b0;
        store_ctl.wr_en = 1'b0;
        store_ctl.clr   = cfg_xfer;
        div_start       = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            S_IDLE:   store_ctl.rd_en = in_xfer;
            S_UPDATE: store_ctl.wr_en = 1'b1;
            S_START:  div_start = 1'b1;
            S_DIV:    out_load = div_done && out_free;
            S_HOLD:   out_load = out_free;
            default: begin
                store_ctl.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_win   <= WIN_RESET;
            r_pos   <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_xfer) begin
                r_win   <= i_cfg_window_size;
                r_pos   <= '0;
                r_total <= '0;
            end else if (r_state == S_UPDATE) begin
                r_total <= r_total + TOT_W'(r_sample)
                           - TOT_W'(signed'(old_slot));
                r_pos   <= (pos_inc >= n_eff) ? '0 : PW'(pos_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample <= i_sample;
            r_slot   <= pos_eff;
        end
    end

    rwa_store #(
        .DEPTH (WINDOW_DEPTH),
        .DW    (SAMPLE_WIDTH),
        .AW    (PW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_addr    ((r_state == S_IDLE) ? pos_eff : r_slot),
        .i_wr_data (r_sample),
        .o_rd_data (old_slot)
    );

    rwa_div #(
        .TOT_W (TOT_W),
        .NW    (NW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_total   (r_total),
        .i_divisor (n_eff),
        .o_done    (div_done),
        .o_neg     (div_neg),
        .o_quot    (div_quot)
    );

    assign avg_full = div_neg ? (-div_quot) : div_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_average <= avg_full[SAMPLE_WIDTH-1:0];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_average;

endmodule
